### rtl/core/ipm_pkg.sv
// Shared types, constants and helper functions of the inverse perspective map generator.
package ipm_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_CAM_X        = 3'd0,
      REG_CAM_Y        = 3'd1,
      REG_CAM_Z        = 3'd2,
      REG_YAW_BASE     = 3'd3,
      REG_PITCH_BASE   = 3'd4,
      REG_U_PER_RADIAN = 3'd5,
      REG_V_PER_RADIAN = 3'd6,
      REG_PIXEL_SCALES = 3'd7
   } ipm_reg_type;

   // Angle constants: pi/2 in Q8.24 and the same rounded to Q16.16.
   localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic [16:0]        HALF_PI_Q16 = 17'd102944;

   // Number of CORDIC rotations and how many run in one pipeline stage.
   localparam int CORDIC_ITERS     = 24;
   localparam int CORDIC_PER_STAGE = 4;
   localparam int CORDIC_STAGES    = CORDIC_ITERS / CORDIC_PER_STAGE;

   // Square root: 32 result bits, four per stage.
   localparam int SQRT_PER_STAGE = 4;
   localparam int SQRT_STAGES    = 32 / SQRT_PER_STAGE;

   // CORDIC angle table, atan(2^-i) in Q8.24.
   function automatic logic signed [27:0] atan_tab(input logic [4:0] idx);
      logic signed [27:0] val;
      unique case (idx)
         5'd0:  val = 28'sd13176795;
         5'd1:  val = 28'sd7778716;
         5'd2:  val = 28'sd4110060;
         5'd3:  val = 28'sd2086331;
         5'd4:  val = 28'sd1047214;
         5'd5:  val = 28'sd524117;
         5'd6:  val = 28'sd262123;
         5'd7:  val = 28'sd131069;
         5'd8:  val = 28'sd65536;
         5'd9:  val = 28'sd32768;
         5'd10: val = 28'sd16384;
         5'd11: val = 28'sd8192;
         5'd12: val = 28'sd4096;
         5'd13: val = 28'sd2048;
         5'd14: val = 28'sd1024;
         5'd15: val = 28'sd512;
         5'd16: val = 28'sd256;
         5'd17: val = 28'sd128;
         5'd18: val = 28'sd64;
         5'd19: val = 28'sd32;
         5'd20: val = 28'sd16;
         5'd21: val = 28'sd8;
         5'd22: val = 28'sd4;
         5'd23: val = 28'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Position of the highest set bit of a 48-bit word, zero for zero.
   function automatic logic [5:0] msb48(input logic [47:0] v);
      logic [5:0] pos;
      pos = '0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            pos = 6'(i);
         end
      end
      return pos;
   endfunction

endpackage

### rtl/core/ipm_if.sv
// Valid/ready channel interfaces for the pixel request and the map response.
interface ipm_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] out_row;
   logic [8:0] out_col;

   modport source (output valid, output out_row, output out_col, input ready);
   modport sink   (input valid, input out_row, input out_col, output ready);
endinterface

interface ipm_rsp_if;
   logic        valid;
   logic        ready;
   logic [26:0] map_u;
   logic [26:0] map_v;
   logic        in_range;

   modport source (output valid, output map_u, output map_v, output in_range, input ready);
   modport sink   (input valid, input map_u, input map_v, input in_range, output ready);
endinterface

### rtl/core/inverse_perspective_map_gen.sv
// Top level of the inverse perspective map generator: register file and main pipeline.
//
// Usage. Each request beat carries one top-view pixel (out_row, out_col); each
// response beat carries the matching camera-image position map_u, map_v in
// unsigned Q16.16 and in_range. Out-of-image points come back as zeros with
// in_range low. Responses leave in request order, exactly one per request.
// There are 25 register stages, the first loaded at the accepting edge.
// Throughput is one beat per clock while the receiver does not stall: a new
// request enters every cycle. The depth is set by the 32-bit square root
// (eight stages of four digits) followed by the 24-step CORDIC arctangent
// (six stages of four rotations). The whole pipeline moves as one; when the
// receiver stalls a waiting response, every stage holds and req.ready drops
// in the same cycle, so nothing is lost or repeated. The user must see that
// registers are written over the csr_ APB port (register i at byte address
// 8*i) only while no beat is in flight; the block itself does not enforce it.
// A synchronous reset clears all pipeline valid bits and configuration registers to 0.
module inverse_perspective_map_gen #(
   parameter int OUT_WIDTH  = 512,
   parameter int OUT_HEIGHT = 512,
   parameter int SRC_WIDTH  = 1024,
   parameter int SRC_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ipm_req_if.sink     req,
   ipm_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LAT = 25;
   localparam int NSQ = ipm_pkg::SQRT_STAGES;
   localparam logic [48:0] LIMIT_U = 49'(SRC_WIDTH) << 16;
   localparam logic [48:0] LIMIT_V = 49'(SRC_HEIGHT) << 16;

   // Configuration registers.
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff, yaw_ff, pitch_ff;
   logic [31:0]        uscale_ff, vscale_ff;
   logic [63:0]        scales_ff;
   logic               csr_wr;
   ipm_pkg::ipm_reg_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = ipm_pkg::ipm_reg_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff  <= '0;
         cam_y_ff  <= '0;
         cam_z_ff  <= '0;
         yaw_ff    <= '0;
         pitch_ff  <= '0;
         uscale_ff <= '0;
         vscale_ff <= '0;
         scales_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            ipm_pkg::REG_CAM_X:        cam_x_ff  <= csr_pwdata[31:0];
            ipm_pkg::REG_CAM_Y:        cam_y_ff  <= csr_pwdata[31:0];
            ipm_pkg::REG_CAM_Z:        cam_z_ff  <= csr_pwdata[31:0];
            ipm_pkg::REG_YAW_BASE:     yaw_ff    <= csr_pwdata[31:0];
            ipm_pkg::REG_PITCH_BASE:   pitch_ff  <= csr_pwdata[31:0];
            ipm_pkg::REG_U_PER_RADIAN: uscale_ff <= csr_pwdata[31:0];
            ipm_pkg::REG_V_PER_RADIAN: vscale_ff <= csr_pwdata[31:0];
            ipm_pkg::REG_PIXEL_SCALES: scales_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_idx)
         ipm_pkg::REG_CAM_X:        csr_prdata = {{32{cam_x_ff[31]}}, cam_x_ff};
         ipm_pkg::REG_CAM_Y:        csr_prdata = {{32{cam_y_ff[31]}}, cam_y_ff};
         ipm_pkg::REG_CAM_Z:        csr_prdata = {{32{cam_z_ff[31]}}, cam_z_ff};
         ipm_pkg::REG_YAW_BASE:     csr_prdata = {{32{yaw_ff[31]}}, yaw_ff};
         ipm_pkg::REG_PITCH_BASE:   csr_prdata = {{32{pitch_ff[31]}}, pitch_ff};
         ipm_pkg::REG_U_PER_RADIAN: csr_prdata = {32'd0, uscale_ff};
         ipm_pkg::REG_V_PER_RADIAN: csr_prdata = {32'd0, vscale_ff};
         ipm_pkg::REG_PIXEL_SCALES: csr_prdata = scales_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // Pipeline valid bits; all stages advance together unless the output stalls.
   logic [LAT-1:0] vld_ff;
   logic           adv;

   assign adv       = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   // Stage 1: pixel offsets times the inverse pixel scales.
   logic signed [13:0] colx_c, rowx_c;
   logic signed [46:0] px_in, py_in, px_ff, py_ff;

   always_comb begin
      colx_c = 14'({4'b0000, req.out_col, 1'b0}) - 14'(OUT_WIDTH - 1);
      rowx_c = 14'(OUT_HEIGHT) - 14'({5'b00000, req.out_row});
      px_in  = colx_c * $signed({1'b0, scales_ff[31:0]});
      py_in  = rowx_c * $signed({1'b0, scales_ff[63:32]});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // Stage 2: ground offsets from the camera in units of 2^-17, magnitudes and sign.
   logic signed [47:0] dx_c, dy_c;
   logic signed [46:0] ty_c;
   logic [47:0]        ax_in, ay_in, ax_ff, ay_ff;
   logic               sgnu_ff;

   always_comb begin
      dx_c  = {px_ff[46], px_ff} - {{15{cam_x_ff[31]}}, cam_x_ff, 1'b0};
      ty_c  = py_ff - {{15{cam_y_ff[31]}}, cam_y_ff};
      dy_c  = {ty_c, 1'b0};
      ax_in = dx_c[47] ? 48'(-dx_c) : 48'(dx_c);
      ay_in = dy_c[47] ? 48'(-dy_c) : 48'(dy_c);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         sgnu_ff <= dx_c[47] ^ dy_c[47];
      end
   end

   // Stage 3: common right shift that brings both magnitudes below 2^31.
   logic [5:0]  mpos_c;
   logic [4:0]  k_in, k_ff;
   logic [30:0] sx_ff, sy_ff;

   always_comb begin
      mpos_c = ipm_pkg::msb48(ax_ff | ay_ff);
      k_in   = (mpos_c > 6'd30) ? 5'(mpos_c - 6'd30) : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_ff  <= k_in;
         sx_ff <= 31'(ax_ff >> k_in);
         sy_ff <= 31'(ay_ff >> k_in);
      end
   end

   // Stage 4 and 5: squares, then their sum.
   logic [61:0] sqx_ff, sqy_ff;
   logic [62:0] sum_ff;
   logic [4:0]  k4_ff, k5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= sx_ff * sx_ff;
         sqy_ff <= sy_ff * sy_ff;
         k4_ff  <= k_ff;
         sum_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         k5_ff  <= k4_ff;
      end
   end

   // Digit-by-digit integer square root, four result bits per stage.
   logic [34:0] sq_rem   [NSQ+1];
   logic [31:0] sq_root  [NSQ+1];
   logic [63:0] sq_v     [NSQ+1];
   logic [4:0]  sq_k     [NSQ+1];
   logic [34:0] sq_rem_ff  [NSQ];
   logic [31:0] sq_root_ff [NSQ];
   logic [63:0] sq_v_ff    [NSQ];
   logic [4:0]  sq_k_ff    [NSQ];
   logic [34:0] sq_rem_in  [NSQ];
   logic [31:0] sq_root_in [NSQ];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_v[0]    = {1'b0, sum_ff};
   assign sq_k[0]    = k5_ff;

   for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
      always_comb begin
         logic [34:0] r;
         logic [31:0] q;
         logic [34:0] t;
         r = sq_rem[s];
         q = sq_root[s];
         for (int j = 0; j < ipm_pkg::SQRT_PER_STAGE; j++) begin
            r = {r[32:0], sq_v[s][63 - 2 * (s * ipm_pkg::SQRT_PER_STAGE + j) -: 2]};
            t = {1'b0, q, 2'b01};
            if (r >= t) begin
               r = r - t;
               q = {q[30:0], 1'b1};
            end else begin
               q = {q[30:0], 1'b0};
            end
         end
         sq_rem_in[s]  = r;
         sq_root_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[s]  <= sq_rem_in[s];
            sq_root_ff[s] <= sq_root_in[s];
            sq_v_ff[s]    <= sq_v[s];
            sq_k_ff[s]    <= sq_k[s];
         end
      end

      assign sq_rem[s+1]  = sq_rem_ff[s];
      assign sq_root[s+1] = sq_root_ff[s];
      assign sq_v[s+1]    = sq_v_ff[s];
      assign sq_k[s+1]    = sq_k_ff[s];
   end

   // Stage 14: ground distance, scaled back up by the common shift.
   logic [47:0] dist_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= 48'({16'd0, sq_root[NSQ]} << sq_k[NSQ]);
      end
   end

   // Arctangents: horizontal from stage 2, vertical from stage 14.
   logic [33:0] cz_c;
   logic [47:0] az_c;
   logic [16:0] angu_c, angv_c;

   assign cz_c = {cam_z_ff[31], cam_z_ff, 1'b0};
   assign az_c = cz_c[33] ? 48'(-$signed(cz_c)) : 48'(cz_c);

   ipm_atan u_atan_h (
      .clock (clock),
      .adv   (adv),
      .a     (ax_ff),
      .b     (ay_ff),
      .ang   (angu_c)
   );

   ipm_atan u_atan_v (
      .clock (clock),
      .adv   (adv),
      .a     (az_c),
      .b     (dist_ff),
      .ang   (angv_c)
   );

   // Delay the horizontal angle and its sign to line up with the vertical one.
   logic [16:0] angu_dly_ff [12];
   logic        sgnu_dly_ff [20];

   always_ff @(posedge clock) begin
      if (adv) begin
         angu_dly_ff[0] <= angu_c;
         for (int i = 1; i < 12; i++) begin
            angu_dly_ff[i] <= angu_dly_ff[i-1];
         end
         sgnu_dly_ff[0] <= sgnu_ff;
         for (int i = 1; i < 20; i++) begin
            sgnu_dly_ff[i] <= sgnu_dly_ff[i-1];
         end
      end
   end

   // Stage 23: signed angles relative to the view base.
   logic signed [17:0] sangu_c, sangv_c;
   logic signed [33:0] du_ff, dv_ff;

   always_comb begin
      sangu_c = sgnu_dly_ff[19] ? -$signed({1'b0, angu_dly_ff[11]})
                                : $signed({1'b0, angu_dly_ff[11]});
      sangv_c = cam_z_ff[31] ? -$signed({1'b0, angv_c}) : $signed({1'b0, angv_c});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         du_ff <= {{16{sangu_c[17]}}, sangu_c} - {{2{yaw_ff[31]}}, yaw_ff};
         dv_ff <= {{16{sangv_c[17]}}, sangv_c} - {{2{pitch_ff[31]}}, pitch_ff};
      end
   end

   // Stage 24: scale to source pixels; the difference always fits 32 bits when non-negative.
   logic [63:0] pu_ff, pv_ff;
   logic        negu_ff, negv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pu_ff   <= du_ff[31:0] * uscale_ff;
         pv_ff   <= dv_ff[31:0] * vscale_ff;
         negu_ff <= du_ff[33];
         negv_ff <= dv_ff[33];
      end
   end

   // Stage 25: round, range test, and the output register.
   logic [48:0] qu_c, qv_c;
   logic        oku_c, okv_c;
   logic [26:0] mapu_ff, mapv_ff;
   logic        inr_ff;

   always_comb begin
      qu_c  = {1'b0, pu_ff[63:16]} + 49'(pu_ff[15]);
      qv_c  = {1'b0, pv_ff[63:16]} + 49'(pv_ff[15]);
      oku_c = (uscale_ff == '0) || (!negu_ff && qu_c <= LIMIT_U);
      okv_c = (vscale_ff == '0) || (!negv_ff && qv_c <= LIMIT_V);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mapu_ff <= (oku_c && okv_c) ? qu_c[26:0] : '0;
         mapv_ff <= (oku_c && okv_c) ? qv_c[26:0] : '0;
         inr_ff  <= oku_c && okv_c;
      end
   end

   assign rsp.valid    = vld_ff[LAT-1];
   assign rsp.map_u    = mapu_ff;
   assign rsp.map_v    = mapv_ff;
   assign rsp.in_range = inr_ff;

   // An out-of-range beat carries zero coordinates.
   a_zero_when_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.in_range |-> rsp.map_u == '0 && rsp.map_v == '0)
      else $error("out-of-range response with nonzero coordinates");

   // An accepted request enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // A stalled pipeline keeps every valid bit.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

endmodule

### rtl/core/ipm_atan.sv
// Pipelined CORDIC arctangent of a/b for non-negative operands, result in Q16.16.
module ipm_atan (
   input  logic        clock,
   input  logic        adv,
   input  logic [47:0] a,
   input  logic [47:0] b,
   output logic [16:0] ang
);

   localparam int NS = ipm_pkg::CORDIC_STAGES;

   logic signed [48:0] x_ff [NS+1];
   logic signed [48:0] y_ff [NS+1];
   logic signed [27:0] z_ff [NS+1];
   logic               bz_ff [NS+1];
   logic               az_ff [NS+1];
   logic signed [48:0] x_in [NS+1];
   logic signed [48:0] y_in [NS+1];
   logic signed [27:0] z_in [NS+1];
   logic [16:0]        ang_ff;
   logic [16:0]        ang_in;

   // Normalize both operands together so the larger one sits in bits 40 to 45.
   always_comb begin
      logic [47:0] m;
      logic [5:0]  p;
      logic [47:0] na;
      logic [47:0] nb;
      m  = a | b;
      p  = ipm_pkg::msb48(m);
      na = a;
      nb = b;
      if (p > 6'd45) begin
         na = a >> (p - 6'd45);
         nb = b >> (p - 6'd45);
      end else if (p < 6'd40) begin
         na = a << (6'd40 - p);
         nb = b << (6'd40 - p);
      end
      x_in[0] = $signed({1'b0, nb});
      y_in[0] = $signed({1'b0, na});
      z_in[0] = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]  <= x_in[0];
         y_ff[0]  <= y_in[0];
         z_ff[0]  <= z_in[0];
         bz_ff[0] <= (b == '0);
         az_ff[0] <= (a == '0);
      end
   end

   // Vectoring rotations, four per stage.
   for (genvar s = 0; s < NS; s++) begin : g_rot
      always_comb begin
         logic signed [48:0] xc;
         logic signed [48:0] yc;
         logic signed [48:0] sx;
         logic signed [48:0] sy;
         logic signed [27:0] zc;
         xc = x_ff[s];
         yc = y_ff[s];
         zc = z_ff[s];
         for (int j = 0; j < ipm_pkg::CORDIC_PER_STAGE; j++) begin
            sx = yc >>> (s * ipm_pkg::CORDIC_PER_STAGE + j);
            sy = xc >>> (s * ipm_pkg::CORDIC_PER_STAGE + j);
            if (!yc[48]) begin
               xc = xc + sx;
               yc = yc - sy;
               zc = zc + ipm_pkg::atan_tab(5'(s * ipm_pkg::CORDIC_PER_STAGE + j));
            end else begin
               xc = xc - sx;
               yc = yc + sy;
               zc = zc - ipm_pkg::atan_tab(5'(s * ipm_pkg::CORDIC_PER_STAGE + j));
            end
         end
         x_in[s+1] = xc;
         y_in[s+1] = yc;
         z_in[s+1] = zc;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[s+1]  <= x_in[s+1];
            y_ff[s+1]  <= y_in[s+1];
            z_ff[s+1]  <= z_in[s+1];
            bz_ff[s+1] <= bz_ff[s];
            az_ff[s+1] <= az_ff[s];
         end
      end
   end

   // Clamp to [0, pi/2], round to Q16.16, and apply the zero-operand cases.
   always_comb begin
      logic signed [27:0] zc;
      logic signed [27:0] zr;
      zc = z_ff[NS];
      if (zc < 0) begin
         zc = '0;
      end else if (zc > ipm_pkg::HALF_PI_Q24) begin
         zc = ipm_pkg::HALF_PI_Q24;
      end
      zr = zc + 28'sd128;
      priority if (bz_ff[NS]) begin
         ang_in = ipm_pkg::HALF_PI_Q16;
      end else if (az_ff[NS]) begin
         ang_in = '0;
      end else begin
         ang_in = zr[24:8];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff <= ang_in;
      end
   end

   assign ang = ang_ff;

endmodule

### tb/sv/ipm_tb_if.sv
// Timescale setting for the testbench around the map generator.
`timescale 1ns / 100ps

### tb/sv/testbench.sv
// Testbench for the inverse perspective map generator: random pixels checked against a predictor.
`timescale 1ns / 100ps
module testbench;

   localparam int OUT_W = 512;
   localparam int OUT_H = 512;
   localparam int SRC_W = 1024;
   localparam int SRC_H = 1024;
   localparam int LATENCY = 25;
   localparam longint HALF_PI = 26353589;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [8:0] row;
      logic [8:0] col;
   } pixel_type;

   typedef struct packed {
      logic [26:0] u;
      logic [26:0] v;
      logic        in_range;
   } map_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   ipm_req_if req ();
   ipm_rsp_if rsp ();

   inverse_perspective_map_gen u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Predictor copy of the registers.
   longint cfg_cam_x, cfg_cam_y, cfg_cam_z, cfg_yaw, cfg_pitch;
   longint unsigned cfg_u_scale, cfg_v_scale, cfg_scales;

   pixel_type pending_pixels[$];
   map_type   expected_maps[$];
   int     error_count = 0;
   longint cycle_count = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   bit     recv_hold = 1'b0;
   bit     hold_go = 1'b0;
   bit     req_taken = 1'b0;

   const longint atan_steps[24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Arctangent of a/b in Q16.16 via CORDIC vectoring, both operands non-negative.
   function automatic longint atan_q16(longint unsigned a, longint unsigned b);
      longint x, y, z, sx, sy;
      z = 0;
      if (b == 0) return (HALF_PI + 128) >>> 8;
      if (a == 0) return 0;
      while ((a | b) >= (64'd1 << 46)) begin
         a >>= 1;
         b >>= 1;
      end
      while ((a | b) < (64'd1 << 40)) begin
         a <<= 1;
         b <<= 1;
      end
      x = b;
      y = a;
      for (int i = 0; i < 24; i++) begin
         sx = y >>> i;
         sy = x >>> i;
         if (y >= 0) begin
            x += sx;
            y -= sy;
            z += atan_steps[i];
         end else begin
            x -= sx;
            y += sy;
            z -= atan_steps[i];
         end
      end
      if (z < 0) z = 0;
      if (z > HALF_PI) z = HALF_PI;
      return (z + 128) >>> 8;
   endfunction

   // Scales an angle offset to a source coordinate; returns 0 when not usable.
   function automatic bit angle_to_coord(longint ang, longint base, longint unsigned scale,
                                         longint unsigned lim, output longint unsigned res);
      longint d;
      longint unsigned p, q;
      d = ang - base;
      res = 0;
      if (scale == 0 || d == 0) return 1'b1;
      if (d < 0) return 1'b0;
      if (longint'(0) + d > 64'hFFFF_FFFF_FFFF_FFFF / scale) return 1'b0;
      p = d * scale;
      q = (p >> 16) + ((p >> 15) & 1);
      if (q > lim) return 1'b0;
      res = q;
      return 1'b1;
   endfunction

   function automatic map_type predict_map(pixel_type px);
      longint dx, dy, cz, ang_u, ang_v, inv_sx, inv_sy;
      longint unsigned ax, ay, gnd_dist, mu, mv;
      int k;
      bit ok_u, ok_v;
      map_type m;
      inv_sx = cfg_scales[31:0];
      inv_sy = cfg_scales[63:32];
      dx = (2 * longint'(px.col) - (OUT_W - 1)) * inv_sx - 2 * cfg_cam_x;
      dy = 2 * ((OUT_H - longint'(px.row)) * inv_sy - cfg_cam_y);
      cz = 2 * cfg_cam_z;
      ax = abs64(dx);
      ay = abs64(dy);
      ang_u = atan_q16(ax, ay);
      if (ay == 0) begin
         if (dx < 0) ang_u = -ang_u;
      end else if ((dx < 0) != (dy < 0)) begin
         ang_u = -ang_u;
      end
      k = 0;
      while ((ax >> k) >= (64'd1 << 31) || (ay >> k) >= (64'd1 << 31)) k++;
      gnd_dist = int_sqrt((ax >> k) * (ax >> k) + (ay >> k) * (ay >> k)) << k;
      ang_v = atan_q16(abs64(cz), gnd_dist);
      if (cz < 0) ang_v = -ang_v;
      ok_u = angle_to_coord(ang_u, cfg_yaw, cfg_u_scale, longint'(SRC_W) << 16, mu);
      ok_v = angle_to_coord(ang_v, cfg_pitch, cfg_v_scale, longint'(SRC_H) << 16, mv);
      if (ok_u && ok_v) begin
         m.u = mu[26:0];
         m.v = mv[26:0];
         m.in_range = 1'b1;
      end else begin
         m = '0;
      end
      return m;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Request driver: a waiting beat is held until accepted, then replaced at the next falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.out_row <= '0;
         req.out_col <= '0;
      end else if (!req.valid || req_taken) begin
         if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid <= 1'b1;
            req.out_row <= pending_pixels[0].row;
            req.out_col <= pending_pixels[0].col;
         end else begin
            req.valid <= 1'b0;
            req.out_row <= $urandom;
            req.out_col <= $urandom;
         end
      end
   end

   // Predict at the accepting edge and retire the pending pixel there.
   always @(posedge clock) begin
      req_taken <= !reset && req.valid && req.ready;
      if (!reset && req.valid && req.ready) begin
         expected_maps.push_back(predict_map({req.out_row, req.out_col}));
         void'(pending_pixels.pop_front());
      end
   end

   // Long receiver hold-off, counted in cycles once requested.
   initial begin
      wait (hold_go);
      recv_hold = 1'b1;
      repeat (200) @(posedge clock);
      recv_hold = 1'b0;
   end

   // Response ready, stalled at random or held off for long stretches.
   always @(negedge clock) begin
      rsp.ready <= !reset && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // Response monitor.
   always @(posedge clock) begin
      map_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_maps.size() == 0) begin
            report_mismatch("unexpected beat", rsp.map_u, 0);
         end else begin
            want = expected_maps.pop_front();
            if (rsp.map_u !== want.u) report_mismatch("map_u", rsp.map_u, want.u);
            if (rsp.map_v !== want.v) report_mismatch("map_v", rsp.map_v, want.v);
            if (rsp.in_range !== want.in_range)
               report_mismatch("in_range", rsp.in_range, want.in_range);
         end
      end
   end

   task automatic wait_drained();
      while (pending_pixels.size() > 0 || expected_maps.size() > 0 || req.valid)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic csr_write(ipm_pkg::ipm_reg_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 6'(idx) << 3;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         ipm_pkg::REG_CAM_X:        cfg_cam_x = longint'(signed'(value[31:0]));
         ipm_pkg::REG_CAM_Y:        cfg_cam_y = longint'(signed'(value[31:0]));
         ipm_pkg::REG_CAM_Z:        cfg_cam_z = longint'(signed'(value[31:0]));
         ipm_pkg::REG_YAW_BASE:     cfg_yaw = longint'(signed'(value[31:0]));
         ipm_pkg::REG_PITCH_BASE:   cfg_pitch = longint'(signed'(value[31:0]));
         ipm_pkg::REG_U_PER_RADIAN: cfg_u_scale = value[31:0];
         ipm_pkg::REG_V_PER_RADIAN: cfg_v_scale = value[31:0];
         ipm_pkg::REG_PIXEL_SCALES: cfg_scales = value;
         default: ;
      endcase
   endtask

   // Plausible camera (height 1..8 m either sign, scales near the source image), or extreme values.
   task automatic config_camera(bit extreme);
      if (extreme) begin
         csr_write(ipm_pkg::REG_CAM_X,
                   $urandom_range(1) ? 64'h7FFF_FFFF : 64'hFFFF_FFFF_8000_0000);
         csr_write(ipm_pkg::REG_CAM_Y, $urandom_range(1) ? 64'h7FFF_FFFF : 64'h8000_0000);
         csr_write(ipm_pkg::REG_CAM_Z, {$urandom, $urandom});
         csr_write(ipm_pkg::REG_YAW_BASE, $urandom_range(1) ? 64'h8000_0000 : 64'h7FFF_FFFF);
         csr_write(ipm_pkg::REG_PITCH_BASE, {$urandom, $urandom});
         csr_write(ipm_pkg::REG_U_PER_RADIAN, $urandom_range(1) ? 64'hFFFF_FFFF : 64'h0);
         csr_write(ipm_pkg::REG_V_PER_RADIAN, {32'h0, $urandom});
         csr_write(ipm_pkg::REG_PIXEL_SCALES, {$urandom, $urandom});
      end else begin
         csr_write(ipm_pkg::REG_CAM_X, 64'(32'($urandom_range(2 * 65536)) - 32'd65536));
         csr_write(ipm_pkg::REG_CAM_Y, 64'(-32'sd65536 * $urandom_range(4)));
         csr_write(ipm_pkg::REG_CAM_Z, 64'(32'($urandom_range(65536, 8 * 65536))
                                  * ($urandom_range(3) == 0 ? -1 : 1)));
         csr_write(ipm_pkg::REG_YAW_BASE, 64'(-32'sd51472 - 32'($urandom_range(20000))));
         csr_write(ipm_pkg::REG_PITCH_BASE, 64'(-32'sd40000 + 32'($urandom_range(80000))));
         csr_write(ipm_pkg::REG_U_PER_RADIAN, 64'($urandom_range(300, 1000) << 16));
         csr_write(ipm_pkg::REG_V_PER_RADIAN, 64'($urandom_range(300, 1000) << 16));
         csr_write(ipm_pkg::REG_PIXEL_SCALES,
                   {32'($urandom_range(64, 4096)), 32'($urandom_range(64, 4096))});
      end
   endtask

   task automatic queue_pixel(int row, int col);
      pixel_type px;
      px.row = row;
      px.col = col;
      pending_pixels.push_back(px);
   endtask

   initial begin
      {cfg_cam_x, cfg_cam_y, cfg_cam_z, cfg_yaw, cfg_pitch} = '0;
      {cfg_u_scale, cfg_v_scale, cfg_scales} = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset registers, then zero offsets and the field extremes.
      queue_pixel(0, 0);
      queue_pixel(511, 511);
      wait_drained();
      csr_write(ipm_pkg::REG_PIXEL_SCALES, 64'h0);
      csr_write(ipm_pkg::REG_CAM_Z, 64'hFFFF_0000);
      csr_write(ipm_pkg::REG_V_PER_RADIAN, 64'h0000_8000);
      csr_write(ipm_pkg::REG_U_PER_RADIAN, 64'h0001_0000);
      csr_write(ipm_pkg::REG_PITCH_BASE, 64'hFFFE_0000);
      csr_write(ipm_pkg::REG_YAW_BASE, 64'hFFFE_0000);
      queue_pixel(0, 0);
      queue_pixel(511, 0);
      wait_drained();
      // Zero forward offset: row 512 is unreachable, so put the camera at row 0's ground point.
      csr_write(ipm_pkg::REG_PIXEL_SCALES, {32'h0001_0000, 32'h0001_0000});
      csr_write(ipm_pkg::REG_CAM_Y, 64'(512 * 65536));
      csr_write(ipm_pkg::REG_CAM_X, 64'h0);
      queue_pixel(0, 0);
      queue_pixel(0, 511);
      queue_pixel(0, 255);
      queue_pixel(0, 256);
      queue_pixel(256, 100);
      queue_pixel(256, 400);
      queue_pixel(170, 341);
      queue_pixel(341, 170);
      wait_drained();
      csr_write(ipm_pkg::REG_CAM_X, 64'hFFFF_8000);
      csr_write(ipm_pkg::REG_CAM_Z, 64'h0);
      queue_pixel(0, 255);
      queue_pixel(0, 0);
      wait_drained();

      // Random phases over several camera settings and idle patterns.
      for (int phase = 0; phase < 8; phase++) begin
         config_camera(phase == 3 || phase == 6);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         for (int n = 0; n < 235; n++) begin
            case ($urandom_range(9))
               0: queue_pixel($urandom_range(1) ? 511 : 0, $urandom_range(1) ? 511 : 0);
               default: queue_pixel($urandom_range(511), $urandom_range(511));
            endcase
         end
         if (phase == 2) begin
            // Long hold-off so the pipeline fills and back-pressures the sender.
            hold_go = 1'b1;
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
